/* rtl/core/u2u8_pkg.sv */
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types, constants and the UTF-8 encoder used by the transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_BIG_ENDIAN = 1'b0,
      CSR_FALLBACK   = 1'b1
   } csr_index_type;

   localparam int unsigned ByteW     = 8;
   localparam int unsigned MaxBytes  = 4;
   localparam int unsigned CntW      = $clog2(MaxBytes);
   localparam int unsigned CpW       = 21;
   localparam logic [ByteW-1:0] FallbackReset = 8'h3F;

   // Surrogate prefixes on the top bits of a unit
   localparam logic [4:0] SurrPrefix  = 5'b11011;
   localparam logic [5:0] LeadPrefix  = 6'b110110;
   localparam logic [5:0] TrailPrefix = 6'b110111;

   // One decoded job: up to four output bytes, first in slot 0
   typedef struct packed {
      logic [MaxBytes-1:0][ByteW-1:0] bytes;
      logic [CntW-1:0]                last_idx;
      logic                           replaced;
   } job_type;

   // Encode a code point into its UTF-8 byte sequence
   function automatic job_type encode_cp(input logic [CpW-1:0] cp);
      job_type job;
      job = '0;
      if (cp < 21'h80) begin
         job.bytes[0] = {1'b0, cp[6:0]};
         job.last_idx = 2'd0;
      end else if (cp < 21'h800) begin
         job.bytes[0] = {3'b110, cp[10:6]};
         job.bytes[1] = {2'b10, cp[5:0]};
         job.last_idx = 2'd1;
      end else if (cp < 21'h10000) begin
         job.bytes[0] = {4'b1110, cp[15:12]};
         job.bytes[1] = {2'b10, cp[11:6]};
         job.bytes[2] = {2'b10, cp[5:0]};
         job.last_idx = 2'd2;
      end else begin
         job.bytes[0] = {5'b11110, cp[20:18]};
         job.bytes[1] = {2'b10, cp[17:12]};
         job.bytes[2] = {2'b10, cp[11:6]};
         job.bytes[3] = {2'b10, cp[5:0]};
         job.last_idx = 2'd3;
      end
      return job;
   endfunction

endpackage

/* rtl/core/utf16_to_utf8_transcoder.sv */
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a UTF-16 byte stream into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input words are taken every cycle while full is low; a word that completes
// a unit stalls only while the two-entry job queue is full. Each unit yields
// 0 to 4 output words, and the result register delivers one word per cycle
// while jobs wait and the receiver pops, so throughput is set by the output
// side (a surrogate pair gives four words for four input words). The first
// word for a unit is written into the job queue and then into the result
// register before it reaches the result ports.
module utf16_to_utf8_transcoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  u2u8_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_wr_data,
   input  logic                    push,
   output logic                    full,
   input  logic [7:0]              req_data_byte,
   output logic                    empty,
   input  logic                    pop,
   output logic [7:0]              rsp_utf8_byte,
   output logic                    rsp_last,
   output logic                    rsp_replaced
);

   logic              job_push, job_full, job_pop, job_empty;
   u2u8_pkg::job_type job_data, job_head;

   // Accept and classify input words
   u2u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_push      (push),
      .req_full      (full),
      .req_data_byte (req_data_byte),
      .job_push      (job_push),
      .job_data      (job_data),
      .job_full      (job_full)
   );

   // Decouple front and back
   u2u8_jobq u_jobq (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .full      (job_full),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty)
   );

   // Serialize UTF-8 words
   u2u8_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (job_head),
      .job_empty     (job_empty),
      .job_pop       (job_pop),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_utf8_byte (rsp_utf8_byte),
      .rsp_last      (rsp_last),
      .rsp_replaced  (rsp_replaced)
   );

endmodule

/* rtl/core/u2u8_front.sv */
// ----------------------------------------------------------------------------
// u2u8_front
// Assembles 16-bit units from input words, pairs surrogates and queues jobs.
// ----------------------------------------------------------------------------
module u2u8_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  u2u8_pkg::csr_index_type    csr_index,
   input  logic [7:0]                 csr_wr_data,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_data_byte,
   output logic                       job_push,
   output u2u8_pkg::job_type          job_data,
   input  logic                       job_full
);

   logic       big_endian_ff;
   logic [7:0] fallback_ff;
   logic [7:0] half_unit_ff,   half_unit_in;
   logic       byte_phase_ff,  byte_phase_in;
   logic [9:0] held_lead_ff,   held_lead_in;
   logic       lead_pending_ff, lead_pending_in;
   logic       accept;
   logic [15:0] unit;
   logic [u2u8_pkg::CpW-1:0] pair_cp;
   u2u8_pkg::job_type fallback_job;

   // Stall only on a completing word when the job queue is full
   assign req_full = byte_phase_ff && job_full;
   assign accept   = req_push && !req_full;

   assign unit = big_endian_ff ? {half_unit_ff, req_data_byte}
                               : {req_data_byte, half_unit_ff};
   assign pair_cp = 21'h10000 + {1'b0, held_lead_ff, unit[9:0]};

   always_comb begin
      fallback_job          = '0;
      fallback_job.bytes[0] = fallback_ff;
      fallback_job.replaced = 1'b1;
   end

   // Classify the unit and pick the job
   always_comb begin
      half_unit_in    = half_unit_ff;
      byte_phase_in   = byte_phase_ff;
      held_lead_in    = held_lead_ff;
      lead_pending_in = lead_pending_ff;
      job_push        = 1'b0;
      job_data        = fallback_job;
      if (accept) begin
         if (!byte_phase_ff) begin
            half_unit_in  = req_data_byte;
            byte_phase_in = 1'b1;
         end else begin
            byte_phase_in = 1'b0;
            if (lead_pending_ff) begin
               lead_pending_in = 1'b0;
               held_lead_in    = '0;
               job_push        = 1'b1;
               if (unit[15:10] == u2u8_pkg::TrailPrefix) begin
                  job_data = u2u8_pkg::encode_cp(pair_cp);
               end
            end else if (unit[15:11] != u2u8_pkg::SurrPrefix) begin
               job_push = 1'b1;
               job_data = u2u8_pkg::encode_cp({5'b0, unit});
            end else if (unit[15:10] == u2u8_pkg::LeadPrefix) begin
               held_lead_in    = unit[9:0];
               lead_pending_in = 1'b1;
            end else begin
               job_push = 1'b1;
            end
         end
      end
   end

   // Hold configuration and unit assembly state
   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff   <= 1'b0;
         fallback_ff     <= u2u8_pkg::FallbackReset;
         half_unit_ff    <= '0;
         byte_phase_ff   <= 1'b0;
         held_lead_ff    <= '0;
         lead_pending_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == u2u8_pkg::CSR_BIG_ENDIAN) begin
               big_endian_ff <= csr_wr_data[0];
            end else begin
               fallback_ff <= csr_wr_data;
            end
         end
         half_unit_ff    <= half_unit_in;
         byte_phase_ff   <= byte_phase_in;
         held_lead_ff    <= held_lead_in;
         lead_pending_ff <= lead_pending_in;
      end
   end

endmodule

/* rtl/core/u2u8_jobq.sv */
// ----------------------------------------------------------------------------
// u2u8_jobq
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module u2u8_jobq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u2u8_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output u2u8_pkg::job_type head,
   output logic              empty
);

   u2u8_pkg::job_type slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("job queue over capacity");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("job queue pointers disagree with count");
   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty) else $error("pushed job lost");

endmodule

/* rtl/core/u2u8_back.sv */
// ----------------------------------------------------------------------------
// u2u8_back
// Walks the head job one byte a cycle into the result register, while that register is free or popped.
// ----------------------------------------------------------------------------
module u2u8_back (
   input  logic              clock,
   input  logic              reset,
   input  u2u8_pkg::job_type head,
   input  logic              job_empty,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_utf8_byte,
   output logic              rsp_last,
   output logic              rsp_replaced
);

   logic [u2u8_pkg::CntW-1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;
   logic       last_ff,  last_in;
   logic       rep_ff,   rep_in;
   logic       load;
   logic       at_end;

   assign load   = !job_empty && (!valid_ff || rsp_pop);
   assign at_end = (idx_ff == head.last_idx);

   // Pick the next byte and retire the job on its last byte
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_pop;
      byte_in  = byte_ff;
      last_in  = last_ff;
      rep_in   = rep_ff;
      job_pop  = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head.bytes[idx_ff];
         last_in  = at_end;
         rep_in   = head.replaced;
         if (at_end) begin
            job_pop = 1'b1;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      rep_ff  <= rep_in;
   end

   assign rsp_empty     = !valid_ff;
   assign rsp_utf8_byte = byte_ff;
   assign rsp_last      = last_ff;
   assign rsp_replaced  = rep_ff;

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !job_empty |-> (idx_ff <= head.last_idx)) else $error("byte index past job end");
   a_rep_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rep_ff) |-> last_ff) else $error("fallback word not last");
   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      job_empty |-> (idx_ff == '0)) else $error("index held with no job");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A directed table
// walks the unit extremes, surrogate pairs and every malformed sequence, then
// random phases send mostly well-formed UTF-16 text under changing byte order
// and fallback settings. A predictor tracks the decoder state and every
// popped word is compared against the oldest predicted word.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned RandomBytes = 350;
   localparam int unsigned NumPhases   = 6;

   typedef struct packed {
      logic [7:0] utf8;
      logic       last;
      logic       replaced;
   } utf8_word_type;

   // One directed step: a data word or a register write; typed rows carry
   // their expected output instead of the predicted one
   typedef struct packed {
      logic                    is_csr;
      u2u8_pkg::csr_index_type idx;
      logic [7:0]              value;
      logic                    typed;
      logic                    has_result;
      logic [7:0]              exp_byte;
      logic                    exp_rep;
   } stim_row_type;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    csr_wr_en     = 1'b0;
   u2u8_pkg::csr_index_type csr_index     = u2u8_pkg::CSR_BIG_ENDIAN;
   logic [7:0]              csr_wr_data   = 8'h00;
   logic                    push          = 1'b0;
   logic                    full;
   logic [7:0]              req_data_byte = 8'h00;
   logic                    empty;
   logic                    pop           = 1'b0;
   logic [7:0]              rsp_utf8_byte;
   logic                    rsp_last;
   logic                    rsp_replaced;

   // Side information for the word being driven
   logic          row_typed      = 1'b0;
   logic          row_has_result = 1'b0;
   logic [7:0]    row_exp        = 8'h00;
   logic          row_rep        = 1'b0;

   // Decoder mirror
   logic          be_cfg;
   logic [7:0]    fallback_cfg;
   logic [7:0]    first_half;
   logic          odd_byte;
   logic [9:0]    lead_bits;
   logic          lead_held;

   utf8_word_type fresh[$];
   utf8_word_type utf8_due[$];
   stim_row_type  directed_rows[$];

   int            errors      = 0;
   int unsigned   cycles      = 0;
   int unsigned   burst_left  = 0;
   int unsigned   bytes_sent  = 0;
   int unsigned   pop_left    = 0;
   int unsigned   pop_mode    = 0;

   utf16_to_utf8_transcoder dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .push          (push),
      .full          (full),
      .req_data_byte (req_data_byte),
      .empty         (empty),
      .pop           (pop),
      .rsp_utf8_byte (rsp_utf8_byte),
      .rsp_last      (rsp_last),
      .rsp_replaced  (rsp_replaced)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic void emit(input logic [7:0] b, input logic rep);
      utf8_word_type w;
      w.utf8     = b;
      w.last     = 1'b0;
      w.replaced = rep;
      fresh.push_back(w);
   endfunction

   function automatic void emit_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         emit(cp[7:0], 1'b0);
      end else if (cp < 21'h800) begin
         emit(8'hC0 | 8'(cp >> 6), 1'b0);
         emit(8'h80 | 8'(cp & 21'h3F), 1'b0);
      end else if (cp < 21'h10000) begin
         emit(8'hE0 | 8'(cp >> 12), 1'b0);
         emit(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0);
         emit(8'h80 | 8'(cp & 21'h3F), 1'b0);
      end else begin
         emit(8'hF0 | 8'((cp >> 18) & 21'h7), 1'b0);
         emit(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b0);
         emit(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b0);
         emit(8'h80 | 8'(cp & 21'h3F), 1'b0);
      end
   endfunction

   // Advance the mirror by one input word; results land in fresh
   function automatic void transcode_byte(input logic [7:0] b);
      logic [15:0]   unit;
      utf8_word_type w;
      fresh.delete();
      if (!odd_byte) begin
         first_half = b;
         odd_byte   = 1'b1;
         return;
      end
      odd_byte = 1'b0;
      unit = be_cfg ? {first_half, b} : {b, first_half};
      if (lead_held) begin
         lead_held = 1'b0;
         if (unit[15:10] == u2u8_pkg::TrailPrefix)
            emit_code_point(21'h10000 + {1'b0, lead_bits, unit[9:0]});
         else
            emit(fallback_cfg, 1'b1);
         lead_bits = '0;
      end else if (unit[15:11] != u2u8_pkg::SurrPrefix) begin
         emit_code_point({5'd0, unit});
      end else if (unit[15:10] == u2u8_pkg::LeadPrefix) begin
         lead_bits = unit[9:0];
         lead_held = 1'b1;
      end else begin
         emit(fallback_cfg, 1'b1);
      end
      // Mark the final word of this input
      if (fresh.size() != 0) begin
         w = fresh.pop_back();
         w.last = 1'b1;
         fresh.push_back(w);
      end
   endfunction

   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endfunction

   // ------------------------------------------------------------------
   // Monitor: mirror register writes, predict accepted words, check results
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      utf8_word_type want;
      if (reset) begin
         be_cfg       = 1'b0;
         fallback_cfg = u2u8_pkg::FallbackReset;
         first_half   = '0;
         odd_byte     = 1'b0;
         lead_bits    = '0;
         lead_held    = 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == u2u8_pkg::CSR_BIG_ENDIAN)
               be_cfg = csr_wr_data[0];
            else
               fallback_cfg = csr_wr_data;
         end
         if (push && !full) begin
            transcode_byte(req_data_byte);
            if (row_typed) begin
               if (row_has_result) begin
                  want = {row_exp, 1'b1, row_rep};
                  utf8_due.push_back(want);
               end
            end else begin
               foreach (fresh[i]) utf8_due.push_back(fresh[i]);
            end
         end
         if (pop && !empty) begin
            if (utf8_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, got %h last %b replaced %b",
                        $time, rsp_utf8_byte, rsp_last, rsp_replaced);
            end else begin
               want = utf8_due.pop_front();
               check_field("utf8_byte", want.utf8, rsp_utf8_byte);
               check_field("last", {7'd0, want.last}, {7'd0, rsp_last});
               check_field("replaced", {7'd0, want.replaced}, {7'd0, rsp_replaced});
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("%0t: timeout with %0d words outstanding", $time, utf8_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: steady pops, random pops and short stalls in turn
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (pop_left == 0) begin
         pop_mode = $urandom_range(0, 2);
         pop_left = (pop_mode == 2) ? $urandom_range(1, 6) : $urandom_range(8, 40);
      end
      pop_left--;
      case (pop_mode)
         0:       pop <= 1'b1;
         1:       pop <= 1'($urandom_range(0, 1));
         default: pop <= 1'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   // Drive one word in bursts with random gaps; return at the next falling edge
   task automatic send_byte(input logic [7:0] b, input logic typed, input logic has,
                            input logic [7:0] exp_b, input logic rep);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      push           <= 1'b1;
      req_data_byte  <= b;
      row_typed      <= typed;
      row_has_result <= has;
      row_exp        <= exp_b;
      row_rep        <= rep;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_unit(input logic [15:0] u);
      if (be_cfg) begin
         send_byte(u[15:8], 1'b0, 1'b0, 8'h00, 1'b0);
         send_byte(u[7:0], 1'b0, 1'b0, 8'h00, 1'b0);
      end else begin
         send_byte(u[7:0], 1'b0, 1'b0, 8'h00, 1'b0);
         send_byte(u[15:8], 1'b0, 1'b0, 8'h00, 1'b0);
      end
   endtask

   // Hold input and wait until every predicted word has been popped
   task automatic settle();
      push <= 1'b0;
      burst_left = 0;
      while (utf8_due.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // Pulse the write enable for one cycle, then drop it before returning
   task automatic write_csr(input u2u8_pkg::csr_index_type idx, input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly well-formed text, some malformed surrogates and raw noise
   task automatic send_random_sequence();
      int unsigned pick;
      logic [15:0] u;
      pick = $urandom_range(0, 99);
      u = 16'($urandom);
      if (pick < 20) begin
         send_unit(16'($urandom_range(0, 'h7F)));
      end else if (pick < 35) begin
         send_unit(16'($urandom_range('h80, 'h7FF)));
      end else if (pick < 55) begin
         u = 16'($urandom_range('h800, 'hFFFF));
         if (u[15:11] == u2u8_pkg::SurrPrefix) u = u ^ 16'h2000;
         send_unit(u);
      end else if (pick < 78) begin
         u[15:10] = u2u8_pkg::LeadPrefix;
         send_unit(u);
         u = 16'($urandom);
         u[15:10] = u2u8_pkg::TrailPrefix;
         send_unit(u);
      end else if (pick < 84) begin
         // lone trail
         u[15:10] = u2u8_pkg::TrailPrefix;
         send_unit(u);
      end else if (pick < 90) begin
         // lead followed by an arbitrary unit
         u[15:10] = u2u8_pkg::LeadPrefix;
         send_unit(u);
         send_unit(16'($urandom));
      end else if (pick < 94) begin
         // lead followed by lead
         u[15:10] = u2u8_pkg::LeadPrefix;
         send_unit(u);
         u = 16'($urandom);
         u[15:10] = u2u8_pkg::LeadPrefix;
         send_unit(u);
      end else if (pick < 97) begin
         send_unit(u);
      end else begin
         // stray word shifts the unit alignment
         send_byte(u[7:0], 1'b0, 1'b0, 8'h00, 1'b0);
      end
   endtask

   function automatic stim_row_type data_row(input logic [7:0] v);
      return '{1'b0, u2u8_pkg::CSR_BIG_ENDIAN, v, 1'b0, 1'b0, 8'h00, 1'b0};
   endfunction

   function automatic stim_row_type quiet_row(input logic [7:0] v);
      return '{1'b0, u2u8_pkg::CSR_BIG_ENDIAN, v, 1'b1, 1'b0, 8'h00, 1'b0};
   endfunction

   function automatic stim_row_type typed_row(input logic [7:0] v, input logic [7:0] e,
                                              input logic rep);
      return '{1'b0, u2u8_pkg::CSR_BIG_ENDIAN, v, 1'b1, 1'b1, e, rep};
   endfunction

   function automatic stim_row_type csr_row(input u2u8_pkg::csr_index_type idx,
                                            input logic [7:0] v);
      return '{1'b1, idx, v, 1'b0, 1'b0, 8'h00, 1'b0};
   endfunction

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int unsigned phase_end;
      logic        be_next;
      logic [7:0]  fb_next;

      directed_rows = '{
         // little endian, reset fallback: ASCII, zero, 0xFFFF
         quiet_row(8'h41), typed_row(8'h00, 8'h41, 1'b0),
         quiet_row(8'h00), typed_row(8'h00, 8'h00, 1'b0),
         data_row(8'hFF),  data_row(8'hFF),
         // lone trail
         quiet_row(8'h00), typed_row(8'hDC, 8'h3F, 1'b1),
         // lowest and highest surrogate pairs
         quiet_row(8'h00), quiet_row(8'hD8), data_row(8'h00), data_row(8'hDC),
         quiet_row(8'hFF), quiet_row(8'hDB), data_row(8'hFF), data_row(8'hDF),
         // lead then a plain unit, lead then lead
         quiet_row(8'h00), quiet_row(8'hD8), quiet_row(8'h41), typed_row(8'h00, 8'h3F, 1'b1),
         quiet_row(8'h00), quiet_row(8'hD8), quiet_row(8'h00), typed_row(8'hD8, 8'h3F, 1'b1),
         // switch byte order with half a unit held
         csr_row(u2u8_pkg::CSR_FALLBACK, 8'h00),
         quiet_row(8'h00),
         csr_row(u2u8_pkg::CSR_BIG_ENDIAN, 8'h01),
         typed_row(8'h41, 8'h41, 1'b0),
         // big endian lone trail with a zero fallback
         quiet_row(8'hDF), typed_row(8'hFF, 8'h00, 1'b1)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            settle();
            write_csr(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            send_byte(directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].has_result, directed_rows[i].exp_byte,
                      directed_rows[i].exp_rep);
         end
      end

      // Random phases, each under its own setting; state carries across
      for (int p = 0; p < NumPhases; p++) begin
         settle();
         be_next = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
         case (p)
            0:       fb_next = 8'hFF;
            1:       fb_next = 8'h00;
            2:       fb_next = u2u8_pkg::FallbackReset;
            default: fb_next = 8'($urandom_range(0, 255));
         endcase
         write_csr(u2u8_pkg::CSR_BIG_ENDIAN, {7'd0, be_next});
         write_csr(u2u8_pkg::CSR_FALLBACK, fb_next);
         phase_end = bytes_sent + RandomBytes / NumPhases;
         while (bytes_sent < phase_end) send_random_sequence();
      end

      settle();
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
rtl/core/u2u8_pkg.sv
rtl/core/u2u8_front.sv
rtl/core/u2u8_jobq.sv
rtl/core/u2u8_back.sv
rtl/core/utf16_to_utf8_transcoder.sv
bench/testbench.sv
